### design/cle_pkg.sv
// Shared types, constants and helpers for the console line editor/tokenizer.
// No dependencies; every other design file but cle_if refers to it by scoped names.
package cle_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int MAX_ARGS     = 10;
    localparam int CNT_W        = 4;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    // Commands queued from the classifier to the executor
    localparam logic [1:0] OP_PRINT = 2'd0;
    localparam logic [1:0] OP_BS    = 2'd1;
    localparam logic [1:0] OP_CTRLC = 2'd2;
    localparam logic [1:0] OP_LINE  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CTRL_MAX = 8'h1F;

    localparam logic [7:0] PROMPT_BYTES [0:5] = '{8'h6F, 8'h62, 8'h63, 8'h20, 8'h24, 8'h20};

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        data;
        logic [ADDR_W-1:0] pos;   // store offset for a print, line length for a line end
    } t_cmd;

    // Index of the final echo beat of each command
    function automatic logic [2:0] seq_last(input logic [1:0] op);
        logic [2:0] r;
        case (op)
            OP_PRINT: r = 3'd0;
            OP_BS:    r = 3'd2;
            OP_CTRLC: r = 3'd7;
            OP_LINE:  r = 3'd1;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] echo_char(input logic [1:0] op, input logic [2:0] step,
                                             input logic [7:0] data);
        logic [7:0] r;
        case (op)
            OP_PRINT: r = data;
            OP_BS:    r = (step == 3'd1) ? CH_SPACE : CH_BS;
            OP_CTRLC: begin
                if (step == 3'd0) r = CH_CR;
                else if (step == 3'd1) r = CH_LF;
                else r = PROMPT_BYTES[step - 3'd2];
            end
            OP_LINE:  r = (step == 3'd0) ? CH_CR : CH_LF;
            default:  r = data;
        endcase
        return r;
    endfunction

endpackage

### design/cle_if.sv
// Valid/ready channel interfaces for received bytes and for results.
// Depends on nothing.
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] echo_byte;
    logic [3:0] token_index;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic [3:0] token_count;
    logic       last;
    modport source (output valid, output kind, output echo_byte, output token_index,
                    output token_start, output token_length, output token_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input echo_byte, input token_index,
                    input token_start, input token_length, input token_count,
                    input last, output ready);
endinterface

### design/cle_front.sv
// Front end: accepts received bytes, classifies them and tracks the fill count.
// Depends on cle_pkg and cle_in_if.
module cle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cle_in_if.sink               i_in,
    input  logic                 i_push_ready,
    output logic                 o_push,
    output cle_pkg::t_cmd        o_cmd
);

    logic [cle_pkg::ADDR_W-1:0] r_fill;
    logic [cle_pkg::ADDR_W-1:0] n_fill;
    logic                       acc;
    logic [7:0]                 c;

    assign i_in.ready = i_push_ready;
    assign acc        = i_in.valid && i_push_ready;
    assign c          = i_in.rx_byte;

    always_comb begin
        n_fill      = r_fill;
        o_push      = 1'b0;
        o_cmd.op    = cle_pkg::OP_PRINT;
        o_cmd.data  = c;
        o_cmd.pos   = r_fill;
        if (acc) begin
            if (c == cle_pkg::CH_LF || c == cle_pkg::CH_CR ||
                r_fill >= cle_pkg::ADDR_W'(cle_pkg::BUFFER_BYTES - 1)) begin
                o_push   = 1'b1;
                o_cmd.op = cle_pkg::OP_LINE;
                n_fill   = '0;
            end else if (c == cle_pkg::CH_BS) begin
                // backspace on an empty line produces nothing
                if (r_fill != '0) begin
                    o_push   = 1'b1;
                    o_cmd.op = cle_pkg::OP_BS;
                    n_fill   = r_fill - 1'b1;
                end
            end else if (c == cle_pkg::CH_ETX) begin
                o_push   = 1'b1;
                o_cmd.op = cle_pkg::OP_CTRLC;
                n_fill   = '0;
            end else if (c > cle_pkg::CTRL_MAX) begin
                o_push   = 1'b1;
                o_cmd.op = cle_pkg::OP_PRINT;
                n_fill   = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

### design/cle_fifo.sv
// Short command queue between the classifier and the executor.
// Depends on cle_pkg.
module cle_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cle_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output cle_pkg::t_cmd o_cmd
);

    cle_pkg::t_cmd               r_ent [0:cle_pkg::Q_DEPTH-1];
    logic [cle_pkg::Q_PTR_W-1:0] r_wr;
    logic [cle_pkg::Q_PTR_W-1:0] r_rd;
    logic [cle_pkg::Q_PTR_W:0]   r_cnt;

    assign o_ready = r_cnt != (cle_pkg::Q_PTR_W+1)'(cle_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### design/cle_back.sv
// Back end: runs queued commands, holds the line store, scans tokens at line end
// and drives the result register. Depends on cle_pkg and cle_out_if.
module cle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cle_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    cle_out_if.source     o_out
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ECHO    = 3'd1;
    localparam logic [2:0] ST_SCAN_RD = 3'd2;
    localparam logic [2:0] ST_SCAN_EV = 3'd3;
    localparam logic [2:0] ST_TAIL    = 3'd4;
    localparam logic [2:0] ST_LINE    = 3'd5;

    logic [7:0]                 r_mem [0:cle_pkg::BUFFER_BYTES-1];
    logic [7:0]                 r_rd_data;

    logic [2:0]                 r_state;
    logic [1:0]                 r_op;
    logic [7:0]                 r_data;
    logic [cle_pkg::ADDR_W-1:0] r_len;
    logic [2:0]                 r_step;
    logic [cle_pkg::ADDR_W-1:0] r_idx;
    logic [cle_pkg::ADDR_W-1:0] r_start;
    logic                       r_in_tok;
    logic [cle_pkg::CNT_W-1:0]  r_cnt;

    logic                       r_o_valid;
    logic [1:0]                 r_o_kind;
    logic [7:0]                 r_o_echo;
    logic [3:0]                 r_o_tidx;
    logic [7:0]                 r_o_tstart;
    logic [7:0]                 r_o_tlen;
    logic [3:0]                 r_o_tcnt;
    logic                       r_o_last;

    logic                       out_free;
    logic                       is_sp;
    logic                       at_end;

    assign out_free = !r_o_valid || o_out.ready;
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign is_sp    = r_rd_data == cle_pkg::CH_SPACE;
    assign at_end   = ({1'b0, r_idx} + 1'b1) == {1'b0, r_len};

    assign o_out.valid        = r_o_valid;
    assign o_out.kind         = r_o_kind;
    assign o_out.echo_byte    = r_o_echo;
    assign o_out.token_index  = r_o_tidx;
    assign o_out.token_start  = r_o_tstart;
    assign o_out.token_length = r_o_tlen;
    assign o_out.token_count  = r_o_tcnt;
    assign o_out.last         = r_o_last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.op == cle_pkg::OP_PRINT) begin
            r_mem[i_q_cmd.pos] <= i_q_cmd.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready) r_o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_op     <= i_q_cmd.op;
                        r_data   <= i_q_cmd.data;
                        r_len    <= i_q_cmd.pos;
                        r_step   <= 3'd0;
                        r_idx    <= '0;
                        r_in_tok <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= ST_ECHO;
                    end
                end
                ST_ECHO: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_kind   <= cle_pkg::KIND_ECHO;
                        r_o_echo   <= cle_pkg::echo_char(r_op, r_step, r_data);
                        r_o_tidx   <= '0;
                        r_o_tstart <= '0;
                        r_o_tlen   <= '0;
                        r_o_tcnt   <= '0;
                        r_o_last   <= (r_step == cle_pkg::seq_last(r_op)) &&
                                      (r_op != cle_pkg::OP_LINE);
                        if (r_step == cle_pkg::seq_last(r_op)) begin
                            if (r_op != cle_pkg::OP_LINE) r_state <= ST_IDLE;
                            else if (r_len == '0)          r_state <= ST_LINE;
                            else                           r_state <= ST_SCAN_RD;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    r_state <= ST_SCAN_EV;
                end
                ST_SCAN_EV: begin
                    if (out_free) begin
                        if (r_idx == '0 && is_sp) begin
                            // leading space: the line yields no tokens
                            r_state <= ST_LINE;
                        end else if (r_in_tok && is_sp) begin
                            r_o_valid  <= 1'b1;
                            r_o_kind   <= cle_pkg::KIND_TOKEN;
                            r_o_echo   <= '0;
                            r_o_tidx   <= r_cnt;
                            r_o_tstart <= 8'(r_start);
                            r_o_tlen   <= 8'(r_idx - r_start);
                            r_o_tcnt   <= '0;
                            r_o_last   <= 1'b0;
                            r_cnt      <= r_cnt + 1'b1;
                            r_in_tok   <= 1'b0;
                            if (r_cnt + 1'b1 == cle_pkg::CNT_W'(cle_pkg::MAX_ARGS)) begin
                                r_state <= ST_LINE;
                            end else if (at_end) begin
                                r_state <= ST_TAIL;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_SCAN_RD;
                            end
                        end else begin
                            if (!r_in_tok && !is_sp) begin
                                r_in_tok <= 1'b1;
                                r_start  <= r_idx;
                            end
                            if (at_end) begin
                                r_state <= ST_TAIL;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_SCAN_RD;
                            end
                        end
                    end
                end
                ST_TAIL: begin
                    // token still open at the end of the line
                    if (out_free) begin
                        if (r_in_tok) begin
                            r_o_valid  <= 1'b1;
                            r_o_kind   <= cle_pkg::KIND_TOKEN;
                            r_o_echo   <= '0;
                            r_o_tidx   <= r_cnt;
                            r_o_tstart <= 8'(r_start);
                            r_o_tlen   <= 8'(r_len - r_start);
                            r_o_tcnt   <= '0;
                            r_o_last   <= 1'b0;
                            r_cnt      <= r_cnt + 1'b1;
                        end
                        r_state <= ST_LINE;
                    end
                end
                ST_LINE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_kind   <= cle_pkg::KIND_LINE;
                        r_o_echo   <= '0;
                        r_o_tidx   <= '0;
                        r_o_tstart <= '0;
                        r_o_tlen   <= '0;
                        r_o_tcnt   <= r_cnt;
                        r_o_last   <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### design/console_line_editor_tokenizer_core.sv
// Top level of the console line editor/tokenizer: classifier, command queue, executor.
// Depends on cle_pkg, cle_if, cle_front, cle_fifo and cle_back.
//
// Usage:
//   i_in carries one received console byte per beat (valid/ready). o_out carries
//   result beats: echo bytes, token reports (start, length, index) and a
//   line-complete beat with the token count; last marks the final beat of a byte.
//   A byte is classified and the fill count updated in the cycle it is taken; it
//   then waits in a two-entry command queue for the executor.
//   The executor fetches a command, then sends its echo beats. A line end takes
//   the fetch, the CR LF beats, a read and an evaluate step per held byte scanned,
//   a step to close a token open at the end and the line-complete beat; an empty
//   line skips the scan, and a leading space or MAX_ARGS tokens stop it early.
//   The registered line store read is what paces the scan.
//   Ignored control bytes are taken without results whenever the queue has room.
//   Reset clears the fill count, queue and executor state; the line store needs
//   no clearing since only bytes written in the current line are ever read.
//   A stalled receiver holds the result register; the executor then waits and
//   the queue fills, after which i_in.ready drops.
module console_line_editor_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cle_in_if.sink     i_in,
    cle_out_if.source  o_out
);

    logic          push;
    logic          push_ready;
    cle_pkg::t_cmd push_cmd;
    logic          q_valid;
    logic          q_pop;
    cle_pkg::t_cmd q_cmd;

    cle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    cle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (push_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

### design/cle_checker.sv
// Port-level checks on the result channel of the tokenizer core, bound to the top.
// Depends on cle_pkg.
module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_kind,
    input logic [3:0] i_token_count,
    input logic [3:0] i_token_index,
    input logic       i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind != 2'd3)
        else $error("undefined result kind");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == cle_pkg::KIND_LINE |->
            i_last && i_token_count <= cle_pkg::CNT_W'(cle_pkg::MAX_ARGS))
        else $error("bad line-complete beat");

    a_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == cle_pkg::KIND_TOKEN |->
            !i_last && i_token_index < cle_pkg::CNT_W'(cle_pkg::MAX_ARGS))
        else $error("bad token beat");

endmodule

bind console_line_editor_tokenizer_core cle_checker u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_kind        (o_out.kind),
    .i_token_count (o_out.token_count),
    .i_token_index (o_out.token_index),
    .i_last        (o_out.last)
);

### verif/tb_top.sv
// Self-checking bench for console_line_editor_tokenizer_core: byte stream in, echo/token
// beats out, checked beat by beat against an in-bench line editor and tokenizer.
// Depends on cle_pkg, cle_if and the design sources.
module tb_top;

    localparam int STALL_LIMIT  = 4000;  // covers the longest line scan plus stalls
    localparam int DRAIN_CYCLES = 60;
    localparam int TOTAL_ITEMS  = 330;
    localparam int PRINT_CAP    = 200;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] echo_byte;
        logic [3:0] token_index;
        logic [7:0] token_start;
        logic [7:0] token_length;
        logic [3:0] token_count;
        logic       last;
    } t_console_beat;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cle_in_if  in_if ();
    cle_out_if out_if ();

    console_line_editor_tokenizer_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 clk = ~clk;

    // Shadow of the editor state
    logic [7:0]    line_bytes [0:cle_pkg::BUFFER_BYTES-1];
    int            line_fill = 0;
    t_console_beat owed_beats [$];
    logic [7:0]    rx_backlog [$];

    int errors     = 0;
    int beat_no    = 0;
    int rx_gap     = 0;
    int rx_calm    = 0;
    int tx_stall   = 0;
    int tx_calm    = 0;
    int idle_count = 0;
    int item_count = 0;

    task automatic log_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at result beat %0d: %s", beat_no, what);
    endtask

    // Mostly no idling, some short gaps, a few long ones; occasional calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] word_len_at(input int start);
        int e;
        e = start;
        while (e < line_fill && line_bytes[e] != cle_pkg::CH_SPACE)
            e++;
        return 8'(e - start);
    endfunction

    function automatic t_console_beat mk_beat(input logic [1:0] kind, input logic [7:0] echo,
                                              input int idx, input int start,
                                              input logic [7:0] len, input int cnt);
        t_console_beat b;
        b.kind         = kind;
        b.echo_byte    = echo;
        b.token_index  = 4'(idx);
        b.token_start  = 8'(start);
        b.token_length = len;
        b.token_count  = 4'(cnt);
        b.last         = 1'b0;
        return b;
    endfunction

    // Works out the beats one accepted byte causes and updates the shadow line
    task automatic edit_and_tokenize(input logic [7:0] c);
        t_console_beat burst [$];
        t_console_beat b;
        int            found;
        bit            after_space;
        found = 0;
        after_space = 1'b0;
        if (c == cle_pkg::CH_LF || c == cle_pkg::CH_CR ||
            line_fill >= cle_pkg::BUFFER_BYTES - 1) begin
            burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, 0, 0, 8'd0, 0));
            burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 0, 0, 8'd0, 0));
            if (line_fill > 0 && line_bytes[0] != cle_pkg::CH_SPACE) begin
                burst.push_back(mk_beat(cle_pkg::KIND_TOKEN, 8'd0, 0, 0, word_len_at(0), 0));
                found = 1;
                for (int i = 1; i < line_fill && found < cle_pkg::MAX_ARGS; i++) begin
                    if (line_bytes[i] == cle_pkg::CH_SPACE) begin
                        after_space = 1'b1;
                    end else begin
                        if (after_space) begin
                            burst.push_back(mk_beat(cle_pkg::KIND_TOKEN, 8'd0, found, i,
                                                    word_len_at(i), 0));
                            found++;
                        end
                        after_space = 1'b0;
                    end
                end
            end
            burst.push_back(mk_beat(cle_pkg::KIND_LINE, 8'd0, 0, 0, 8'd0, found));
            line_fill = 0;
        end else if (c == cle_pkg::CH_BS) begin
            if (line_fill > 0) begin
                burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 0, 0, 8'd0, 0));
                burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 0, 0, 8'd0, 0));
                burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 0, 0, 8'd0, 0));
                line_fill--;
            end
        end else if (c == cle_pkg::CH_ETX) begin
            burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, 0, 0, 8'd0, 0));
            burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 0, 0, 8'd0, 0));
            for (int k = 0; k < 6; k++)
                burst.push_back(mk_beat(cle_pkg::KIND_ECHO, cle_pkg::PROMPT_BYTES[k],
                                        0, 0, 8'd0, 0));
            line_fill = 0;
        end else if (c > cle_pkg::CTRL_MAX) begin
            burst.push_back(mk_beat(cle_pkg::KIND_ECHO, c, 0, 0, 8'd0, 0));
            if (line_fill < cle_pkg::BUFFER_BYTES) begin
                line_bytes[line_fill] = c;
                line_fill++;
            end
        end
        for (int k = 0; k < burst.size(); k++) begin
            b = burst[k];
            b.last = (k == burst.size() - 1);
            owed_beats.push_back(b);
        end
    endtask

    task automatic check_beat(input t_console_beat got);
        t_console_beat want;
        if (owed_beats.size() == 0) begin
            log_mismatch($sformatf("unexpected beat kind %0d echo %02h", got.kind,
                                   got.echo_byte));
        end else begin
            want = owed_beats.pop_front();
            if (got.kind !== want.kind)
                log_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.echo_byte !== want.echo_byte)
                log_mismatch($sformatf("echo_byte %02h, want %02h", got.echo_byte,
                                       want.echo_byte));
            if (got.token_index !== want.token_index)
                log_mismatch($sformatf("token_index %0d, want %0d", got.token_index,
                                       want.token_index));
            if (got.token_start !== want.token_start)
                log_mismatch($sformatf("token_start %0d, want %0d", got.token_start,
                                       want.token_start));
            if (got.token_length !== want.token_length)
                log_mismatch($sformatf("token_length %0d, want %0d", got.token_length,
                                       want.token_length));
            if (got.token_count !== want.token_count)
                log_mismatch($sformatf("token_count %0d, want %0d", got.token_count,
                                       want.token_count));
            if (got.last !== want.last)
                log_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
        beat_no++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        item_count++;
    endtask

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(8'h21, 8'hFF));
    endfunction

    // Mostly well-formed lines of short words; some erasing, noise and abandoned lines
    task automatic queue_random_line();
        int words;
        int wlen;
        int r;
        words = $urandom_range(0, 13);
        if ($urandom_range(0, 9) == 0) queue_byte(cle_pkg::CH_SPACE);
        for (int w = 0; w < words; w++) begin
            wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            for (int k = 0; k < wlen; k++) begin
                queue_byte(word_char());
                if ($urandom_range(0, 11) == 0) queue_byte(cle_pkg::CH_BS);
            end
            if ($urandom_range(0, 24) == 0) queue_byte(8'($urandom_range(0, 255)));
            if (w < words - 1) begin
                queue_byte(cle_pkg::CH_SPACE);
                if ($urandom_range(0, 4) == 0) queue_byte(cle_pkg::CH_SPACE);
            end
        end
        if ($urandom_range(0, 7) == 0) queue_byte(cle_pkg::CH_SPACE);
        r = $urandom_range(0, 19);
        if (r == 0) queue_byte(cle_pkg::CH_ETX);
        else if (r < 10) queue_byte(cle_pkg::CH_CR);
        else queue_byte(cle_pkg::CH_LF);
    endtask

    // Driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.rx_byte <= 8'h00;
        end else begin
            if (in_if.valid && in_if.ready)
                edit_and_tokenize(in_if.rx_byte);
            if (!in_if.valid || in_if.ready) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    in_if.valid <= 1'b0;
                end else if (rx_backlog.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.rx_byte <= rx_backlog.pop_front();
                    rx_gap = pick_idle(rx_calm);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_beat('{out_if.kind, out_if.echo_byte, out_if.token_index,
                             out_if.token_start, out_if.token_length, out_if.token_count,
                             out_if.last});
            if (tx_stall > 0) begin
                tx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                tx_stall = pick_idle(tx_calm);
            end
        end
    end

    // Watchdog: cycles with no beat taken on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("timeout: no beat taken for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b0;

        // Directed: empty line, erase on empty, ignored controls
        queue_byte(cle_pkg::CH_CR);
        queue_byte(cle_pkg::CH_BS);
        queue_byte(8'h00);
        queue_byte(cle_pkg::CTRL_MAX);
        queue_byte(8'h07);
        // leading space gives no tokens
        queue_byte(cle_pkg::CH_SPACE);
        queue_byte(8'h71);
        queue_byte(cle_pkg::CH_LF);
        // high bytes and DEL are printable; erase back over the space and 0xFF
        queue_byte(8'h41);
        queue_byte(8'h7F);
        queue_byte(8'hFF);
        queue_byte(cle_pkg::CH_SPACE);
        queue_byte(cle_pkg::CH_BS);
        queue_byte(cle_pkg::CH_BS);
        queue_byte(cle_pkg::CH_CR);
        // Ctrl-C abandons a partial line
        queue_byte(8'h6F);
        queue_byte(8'h6B);
        queue_byte(cle_pkg::CH_ETX);
        // double space and trailing space
        queue_byte(8'h68);
        queue_byte(8'h69);
        queue_byte(cle_pkg::CH_SPACE);
        queue_byte(cle_pkg::CH_SPACE);
        queue_byte(8'h79);
        queue_byte(8'h6F);
        queue_byte(cle_pkg::CH_SPACE);
        queue_byte(cle_pkg::CH_LF);

        // Full buffer, tokens near the end past the argument limit; a backspace ends it
        for (int i = 0; i < cle_pkg::BUFFER_BYTES - 21; i++)
            queue_byte(word_char());
        for (int i = 0; i < 10; i++) begin
            queue_byte(cle_pkg::CH_SPACE);
            queue_byte(word_char());
        end
        queue_byte(cle_pkg::CH_BS);

        while (item_count < TOTAL_ITEMS)
            queue_random_line();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (rx_backlog.size() != 0 || in_if.valid);
        while (owed_beats.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (owed_beats.size() != 0)
            log_mismatch($sformatf("%0d beats never arrived", owed_beats.size()));

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
